@@ hw/rtl/dht_pkg.sv @@
// Shared types and constants for the DHT Huffman table builder.
// No dependencies; used by every module of the block.
`default_nettype none

package dht_pkg;

	localparam int unsigned NUM_LENGTHS = 16;
	localparam int unsigned LEN_AW      = 4;
	localparam int unsigned TDATA_W     = 80;

	localparam logic [1:0] KIND_SYMBOL = 2'd0;
	localparam logic [1:0] KIND_ROW    = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_SHORT    = 3'd1;
	localparam logic [2:0] ERR_CLASS    = 3'd2;
	localparam logic [2:0] ERR_ID       = 3'd3;
	localparam logic [2:0] ERR_OVERFLOW = 3'd4;

	localparam logic [15:0] CODE_NONE   = 16'hffff;
	localparam logic [11:0] MAX_SYMBOLS = 12'd256;
	localparam logic [15:0] MIN_TABLE   = 16'd17;

	typedef struct packed {
		logic [1:0]  kind;
		logic        tclass;
		logic [1:0]  tid;
		logic [7:0]  position;
		logic [7:0]  value;
		logic [15:0] code_first;
		logic [15:0] code_last;
		logic [4:0]  code_length;
		logic [8:0]  offset;
		logic [8:0]  total_codes;
		logic [2:0]  error_code;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

@@ hw/rtl/dht_cnt_ram.sv @@
// Code-length count memory: 16 entries of 8 bits, one write and one read port.
// Read data is registered. Depends on dht_pkg.
`default_nettype none

module dht_cnt_ram (
	input  wire                            clk,
	input  wire                            we,
	input  wire [dht_pkg::LEN_AW-1:0]      waddr,
	input  wire [7:0]                      wdata,
	input  wire [dht_pkg::LEN_AW-1:0]      raddr,
	output logic [7:0]                     rdata
);

	logic [7:0] mem [dht_pkg::NUM_LENGTHS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/dht_out_reg.sv @@
// Result output register: holds one result and packs it onto the master stream.
// Depends on dht_pkg (res_t).
`default_nettype none

module dht_out_reg (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            push,
	input  dht_pkg::res_t                  res,
	output logic                           free,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	// tdata from bit 0: table_class, table_id, position, value, code_first,
	// code_last, code_length, offset, total_codes, error_code, zero fill
	output logic [dht_pkg::TDATA_W-1:0]    m_tdata,
	// tuser: kind
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast
);

	logic          valid_q;
	dht_pkg::res_t res_q;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last;
	assign m_tdata  = {3'b000, res_q.error_code, res_q.total_codes, res_q.offset,
		res_q.code_length, res_q.code_last, res_q.code_first, res_q.value,
		res_q.position, res_q.tid, res_q.tclass};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (free && push) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/jpeg_dht_huffman_table_builder_top.sv @@
// DHT segment parser and canonical Huffman table builder.
// Length, header and count bytes are taken in S_IN; a byte that ends in a segment-done or
// error result then moves to S_DONE or S_ERR to push it. The 16th count is followed by one
// memory read, then 16 rows. A symbol byte moves to S_SYM, which reads the count memory for
// each code length stepped; the first symbol of a table always steps to length 1. Output
// stalls can hold any result. arst_n clears all control state; the count memory has no reset.
`default_nettype none

module jpeg_dht_huffman_table_builder_top (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	// tdata: data_byte
	input  wire [7:0]                      s_tdata,
	// tuser: segment_start
	input  wire                            s_tuser,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	// tdata from bit 0: table_class, table_id, position, value, code_first,
	// code_last, code_length, offset, total_codes, error_code, zero fill
	output logic [dht_pkg::TDATA_W-1:0]    m_tdata,
	// tuser: kind
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast
);

	typedef enum logic [4:0] {
		S_IN   = 5'b00001,
		S_ROWS = 5'b00010,
		S_SYM  = 5'b00100,
		S_DONE = 5'b01000,
		S_ERR  = 5'b10000
	} fsm_t;

	typedef enum logic [4:0] {
		P_IDLE    = 5'b00001,
		P_LENLO   = 5'b00010,
		P_HEADER  = 5'b00100,
		P_COUNTS  = 5'b01000,
		P_SYMBOLS = 5'b10000
	} phase_t;

	fsm_t        fsm_q;
	phase_t      phase_q;
	logic [15:0] rem_q;
	logic        class_q;
	logic [1:0]  id_q;
	logic [3:0]  cpos_q;
	logic [11:0] total_q;
	logic        any_nz_q;
	logic [3:0]  lastnz_q;
	logic [2:0]  err_q;
	logic [3:0]  ri_q;
	logic        rd_ok_q;
	logic [16:0] code_q;
	logic [8:0]  off_q;
	logic [8:0]  idx_q;
	logic [16:0] rcode_q;
	logic [4:0]  rlen_q;
	logic [7:0]  left_q;
	logic [7:0]  symb_q;

	logic          in_acc;
	logic          free;
	logic          push;
	dht_pkg::res_t res;
	logic [3:0]    raddr;
	logic [7:0]    rd_data;
	logic          cnt_we;
	logic [15:0]   rem_dec;
	logic [15:0]   len_full;
	logic [11:0]   total_new;
	logic          row_blank;
	logic          fin_done;
	logic          need_adv;
	logic          sym_fin;
	logic [16:0]   code_sum;

	assign s_tready  = (fsm_q == S_IN);
	assign in_acc    = s_tvalid && s_tready;
	assign cnt_we    = in_acc && !s_tuser && (phase_q == P_COUNTS);
	assign rem_dec   = (rem_q != 16'd0) ? rem_q - 16'd1 : rem_q;
	assign len_full  = {rem_q[15:8], s_tdata};
	assign total_new = total_q + {4'b0000, s_tdata};
	assign row_blank = !any_nz_q || (ri_q > lastnz_q);
	assign fin_done  = (total_q == 12'd0) && (rem_q == 16'd0);
	assign need_adv  = (left_q == 8'd0) && (rlen_q < 5'd16);
	assign sym_fin   = ({3'b000, idx_q} + 12'd1) >= total_q;
	assign code_sum  = code_q + {9'd0, rd_data};

	dht_cnt_ram u_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cpos_q),
		.wdata (s_tdata),
		.raddr (raddr),
		.rdata (rd_data)
	);

	dht_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res      (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always_comb begin
		res   = '0;
		push  = 1'b0;
		raddr = ri_q;
		case (fsm_q)
			S_ROWS: begin
				push             = rd_ok_q && free;
				raddr            = push ? ri_q + 4'd1 : ri_q;
				res.kind         = dht_pkg::KIND_ROW;
				res.tclass       = class_q;
				res.tid          = id_q;
				res.position     = {4'h0, ri_q};
				res.value        = rd_data;
				res.code_first   = row_blank ? dht_pkg::CODE_NONE : code_q[15:0];
				res.code_last    = row_blank ? dht_pkg::CODE_NONE
					: code_q[15:0] + {8'h00, rd_data} - 16'd1;
				res.offset       = off_q;
				res.total_codes  = total_q[8:0];
				res.last         = (ri_q == 4'd15) && !fin_done;
			end
			S_SYM: begin
				raddr            = rlen_q[3:0];
				push             = !need_adv && free;
				res.kind         = dht_pkg::KIND_SYMBOL;
				res.tclass       = class_q;
				res.tid          = id_q;
				res.position     = idx_q[7:0];
				res.value        = symb_q;
				res.code_first   = rcode_q[15:0];
				res.code_length  = rlen_q;
				res.total_codes  = total_q[8:0];
				res.last         = !(sym_fin && (rem_dec == 16'd0));
			end
			S_DONE: begin
				push             = free;
				res.kind         = dht_pkg::KIND_DONE;
				res.last         = 1'b1;
			end
			S_ERR: begin
				push             = free;
				res.kind         = dht_pkg::KIND_ERROR;
				res.error_code   = err_q;
				res.last         = 1'b1;
			end
			default: begin
				push             = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q    <= S_IN;
			phase_q  <= P_IDLE;
			rem_q    <= '0;
			class_q  <= 1'b0;
			id_q     <= '0;
			cpos_q   <= '0;
			total_q  <= '0;
			any_nz_q <= 1'b0;
			lastnz_q <= '0;
			err_q    <= dht_pkg::ERR_NONE;
			ri_q     <= '0;
			rd_ok_q  <= 1'b0;
			code_q   <= '0;
			off_q    <= '0;
			idx_q    <= '0;
			rcode_q  <= '0;
			rlen_q   <= 5'd1;
			left_q   <= '0;
			symb_q   <= '0;
		end else begin
			case (fsm_q)
				S_IN: begin
					if (in_acc) begin
						if (s_tuser) begin
							rem_q   <= {s_tdata, 8'h00};
							phase_q <= P_LENLO;
						end else begin
							case (phase_q)
								P_LENLO: begin
									if (len_full <= 16'd2) begin
										rem_q   <= '0;
										phase_q <= P_IDLE;
										fsm_q   <= S_DONE;
									end else begin
										rem_q   <= len_full - 16'd2;
										phase_q <= P_HEADER;
									end
								end
								P_HEADER: begin
									if (rem_q < dht_pkg::MIN_TABLE) begin
										err_q   <= dht_pkg::ERR_SHORT;
										phase_q <= P_IDLE;
										fsm_q   <= S_ERR;
									end else if (s_tdata[7:4] >= 4'd2) begin
										err_q   <= dht_pkg::ERR_CLASS;
										phase_q <= P_IDLE;
										fsm_q   <= S_ERR;
									end else if (s_tdata[3:0] >= 4'd4) begin
										err_q   <= dht_pkg::ERR_ID;
										phase_q <= P_IDLE;
										fsm_q   <= S_ERR;
									end else begin
										class_q  <= s_tdata[4];
										id_q     <= s_tdata[1:0];
										rem_q    <= rem_q - 16'd1;
										cpos_q   <= '0;
										total_q  <= '0;
										any_nz_q <= 1'b0;
										lastnz_q <= '0;
										phase_q  <= P_COUNTS;
									end
								end
								P_COUNTS: begin
									total_q <= total_new;
									cpos_q  <= cpos_q + 4'd1;
									rem_q   <= rem_dec;
									if (s_tdata != 8'h00) begin
										any_nz_q <= 1'b1;
										lastnz_q <= cpos_q;
									end
									if (cpos_q == 4'd15) begin
										if (total_new > dht_pkg::MAX_SYMBOLS) begin
											err_q   <= dht_pkg::ERR_OVERFLOW;
											phase_q <= P_IDLE;
											fsm_q   <= S_ERR;
										end else if (rem_dec < {4'h0, total_new}) begin
											err_q   <= dht_pkg::ERR_SHORT;
											phase_q <= P_IDLE;
											fsm_q   <= S_ERR;
										end else begin
											ri_q    <= '0;
											rd_ok_q <= 1'b0;
											code_q  <= '0;
											off_q   <= '0;
											fsm_q   <= S_ROWS;
										end
									end
								end
								P_SYMBOLS: begin
									symb_q <= s_tdata;
									fsm_q  <= S_SYM;
								end
								default: begin
									phase_q <= phase_q;
								end
							endcase
						end
					end
				end
				S_ROWS: begin
					if (!rd_ok_q) begin
						rd_ok_q <= 1'b1;
					end else if (push) begin
						ri_q   <= ri_q + 4'd1;
						off_q  <= off_q + {1'b0, rd_data};
						code_q <= {code_sum[15:0], 1'b0};
						if (ri_q == 4'd15) begin
							rd_ok_q <= 1'b0;
							idx_q   <= '0;
							rcode_q <= '0;
							rlen_q  <= '0;
							left_q  <= '0;
							if (total_q == 12'd0) begin
								if (rem_q == 16'd0) begin
									phase_q <= P_IDLE;
									fsm_q   <= S_DONE;
								end else begin
									phase_q <= P_HEADER;
									fsm_q   <= S_IN;
								end
							end else begin
								phase_q <= P_SYMBOLS;
								fsm_q   <= S_IN;
							end
						end
					end
				end
				S_SYM: begin
					if (need_adv) begin
						if (!rd_ok_q) begin
							rd_ok_q <= 1'b1;
						end else begin
							rcode_q <= {rcode_q[15:0], 1'b0};
							rlen_q  <= rlen_q + 5'd1;
							left_q  <= rd_data;
							rd_ok_q <= 1'b0;
						end
					end else if (push) begin
						if (left_q != 8'd0) begin
							rcode_q <= rcode_q + 17'd1;
							left_q  <= left_q - 8'd1;
						end
						idx_q <= idx_q + 9'd1;
						rem_q <= rem_dec;
						if (sym_fin) begin
							if (rem_dec == 16'd0) begin
								phase_q <= P_IDLE;
								fsm_q   <= S_DONE;
							end else begin
								phase_q <= P_HEADER;
								fsm_q   <= S_IN;
							end
						end else begin
							fsm_q <= S_IN;
						end
					end
				end
				S_DONE: begin
					if (push) begin
						fsm_q <= S_IN;
					end
				end
				S_ERR: begin
					if (push) begin
						fsm_q <= S_IN;
					end
				end
				default: begin
					fsm_q <= S_IN;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the DHT Huffman table builder: streams DHT segments and
// predicts every length row, symbol code, segment-done and error result it must produce.
// Depends on dht_pkg and jpeg_dht_huffman_table_builder_top.

import dht_pkg::*;

typedef enum logic [2:0] {
	PARSE_IDLE,
	PARSE_LEN_LO,
	PARSE_HEADER,
	PARSE_COUNTS,
	PARSE_SYMBOLS
} parse_phase_e;

class dht_scoreboard;
	res_t expected_entries[$];
	int mismatches;
	int checked;

	parse_phase_e phase;
	logic [15:0] bytes_left;
	logic cur_class;
	logic [1:0] cur_id;
	logic [7:0] counts[16];
	logic [4:0] count_pos;
	logic [11:0] sym_total;
	logic [8:0] sym_index;
	logic [16:0] run_code;
	logic [4:0] run_len;
	logic [7:0] left_in_len;

	res_t tail;
	bit have_tail;

	function new();
		mismatches = 0;
		checked = 0;
		phase = PARSE_IDLE;
		bytes_left = '0;
		cur_class = 1'b0;
		cur_id = '0;
		count_pos = '0;
		sym_total = '0;
		sym_index = '0;
		run_code = '0;
		run_len = 5'd1;
		left_in_len = '0;
		have_tail = 0;
		foreach (counts[i])
			counts[i] = '0;
	endfunction

	// hold the newest entry back so the final one of a request can carry last
	function void add_result(logic [1:0] kind, logic [7:0] pos, logic [7:0] val,
			logic [15:0] first_code, logic [15:0] last_code, logic [4:0] len,
			logic [8:0] off, logic [2:0] err);
		res_t r;
		logic in_table;
		in_table = (kind == KIND_SYMBOL || kind == KIND_ROW);
		r.kind = kind;
		r.tclass = in_table ? cur_class : 1'b0;
		r.tid = in_table ? cur_id : 2'd0;
		r.position = pos;
		r.value = val;
		r.code_first = first_code;
		r.code_last = last_code;
		r.code_length = len;
		r.offset = off;
		r.total_codes = in_table ? sym_total[8:0] : 9'd0;
		r.error_code = err;
		r.last = 1'b0;
		if (have_tail)
			expected_entries.push_back(tail);
		tail = r;
		have_tail = 1;
	endfunction

	function void fail(logic [2:0] err);
		phase = PARSE_IDLE;
		add_result(KIND_ERROR, 8'd0, 8'd0, 16'd0, 16'd0, 5'd0, 9'd0, err);
	endfunction

	function void table_done();
		if (bytes_left == 16'd0) begin
			phase = PARSE_IDLE;
			add_result(KIND_DONE, 8'd0, 8'd0, 16'd0, 16'd0, 5'd0, 9'd0, ERR_NONE);
		end else begin
			phase = PARSE_HEADER;
		end
	endfunction

	function void emit_rows();
		logic [16:0] code;
		logic [8:0] off;
		logic [15:0] first_code, last_code;
		int lastnz;
		code = '0;
		off = '0;
		lastnz = -1;
		for (int i = 0; i < NUM_LENGTHS; i++)
			if (counts[i] != 8'd0)
				lastnz = i;
		for (int i = 0; i < NUM_LENGTHS; i++) begin
			first_code = code[15:0];
			last_code = code[15:0] + {8'h00, counts[i]} - 16'd1;
			// lengths past the longest used one carry no codes
			if (i > lastnz) begin
				first_code = CODE_NONE;
				last_code = CODE_NONE;
			end
			add_result(KIND_ROW, 8'(i), counts[i], first_code, last_code, 5'd0, off, ERR_NONE);
			off = off + 9'(counts[i]);
			code = (code + 17'(counts[i])) << 1;
		end
	endfunction

	function void note_request(logic [7:0] b, logic start);
		logic [15:0] seg_len;
		if (start) begin
			bytes_left = {b, 8'h00};
			phase = PARSE_LEN_LO;
			return;
		end
		case (phase)
		PARSE_LEN_LO: begin
			seg_len = {bytes_left[15:8], b};
			if (seg_len <= 16'd2) begin
				bytes_left = '0;
				phase = PARSE_IDLE;
				add_result(KIND_DONE, 8'd0, 8'd0, 16'd0, 16'd0, 5'd0, 9'd0, ERR_NONE);
			end else begin
				bytes_left = seg_len - 16'd2;
				phase = PARSE_HEADER;
			end
		end
		PARSE_HEADER: begin
			if (bytes_left < MIN_TABLE)
				fail(ERR_SHORT);
			else if (b[7:4] >= 4'd2)
				fail(ERR_CLASS);
			else if (b[3:0] >= 4'd4)
				fail(ERR_ID);
			else begin
				cur_class = b[4];
				cur_id = b[1:0];
				bytes_left = bytes_left - 16'd1;
				count_pos = '0;
				sym_total = '0;
				phase = PARSE_COUNTS;
			end
		end
		PARSE_COUNTS: begin
			counts[count_pos[3:0]] = b;
			sym_total = sym_total + 12'(b);
			count_pos = count_pos + 5'd1;
			if (bytes_left != 16'd0)
				bytes_left = bytes_left - 16'd1;
			if (count_pos >= 5'd16) begin
				if (sym_total > MAX_SYMBOLS)
					fail(ERR_OVERFLOW);
				else if (bytes_left < 16'(sym_total))
					fail(ERR_SHORT);
				else begin
					emit_rows();
					sym_index = '0;
					run_code = '0;
					run_len = 5'd1;
					left_in_len = counts[0];
					if (sym_total == 12'd0)
						table_done();
					else
						phase = PARSE_SYMBOLS;
				end
			end
		end
		PARSE_SYMBOLS: begin
			// advance to the next length that still has codes
			while (left_in_len == 8'd0 && run_len < 5'd16) begin
				run_code = run_code << 1;
				run_len = run_len + 5'd1;
				left_in_len = counts[4'(run_len - 5'd1)];
			end
			add_result(KIND_SYMBOL, sym_index[7:0], b, run_code[15:0], 16'd0, run_len,
				9'd0, ERR_NONE);
			if (left_in_len != 8'd0) begin
				run_code = run_code + 17'd1;
				left_in_len = left_in_len - 8'd1;
			end
			sym_index = sym_index + 9'd1;
			if (bytes_left != 16'd0)
				bytes_left = bytes_left - 16'd1;
			if (12'(sym_index) >= sym_total)
				table_done();
		end
		default: ;
		endcase
		if (have_tail) begin
			tail.last = 1'b1;
			expected_entries.push_back(tail);
			have_tail = 0;
		end
	endfunction

	task report(string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t MISMATCH %s", $time, msg);
	endtask

	task compare_field(string name, logic [31:0] got_v, logic [31:0] want_v);
		if (got_v !== want_v)
			report($sformatf("result %0d %s: got %0h, expected %0h", checked, name, got_v,
				want_v));
	endtask

	task check_result(logic [1:0] kind_in, logic [TDATA_W-1:0] data, logic last_in);
		res_t want;
		checked++;
		if (expected_entries.size() == 0) begin
			report($sformatf("result %0d: kind %0d arrived with nothing expected", checked,
				kind_in));
			return;
		end
		want = expected_entries.pop_front();
		compare_field("kind", 32'(kind_in), 32'(want.kind));
		compare_field("table_class", 32'(data[0]), 32'(want.tclass));
		compare_field("table_id", 32'(data[2:1]), 32'(want.tid));
		compare_field("position", 32'(data[10:3]), 32'(want.position));
		compare_field("value", 32'(data[18:11]), 32'(want.value));
		compare_field("code_first", 32'(data[34:19]), 32'(want.code_first));
		compare_field("code_last", 32'(data[50:35]), 32'(want.code_last));
		compare_field("code_length", 32'(data[55:51]), 32'(want.code_length));
		compare_field("offset", 32'(data[64:56]), 32'(want.offset));
		compare_field("total_codes", 32'(data[73:65]), 32'(want.total_codes));
		compare_field("error_code", 32'(data[76:74]), 32'(want.error_code));
		compare_field("zero fill", 32'(data[TDATA_W-1:77]), 32'd0);
		compare_field("last", 32'(last_in), 32'(want.last));
	endtask
endclass

module tb;
	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} request_t;

	typedef enum int {
		SEG_GOOD,
		SEG_EMPTY_TABLE,
		SEG_OVERFLOW,
		SEG_TOO_FEW,
		SEG_BAD_HEADER,
		SEG_SHORT
	} segment_kind_e;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	request_t requests[$];
	int directed_count;
	int noise_count = 0;
	int send_idle = 25;
	int recv_idle = 64;
	dht_scoreboard sb;

	jpeg_dht_huffman_table_builder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	function void push_request(logic [7:0] data, logic start);
		request_t r;
		r.data = data;
		r.start = start;
		requests.push_back(r);
	endfunction

	function void push_length(int unsigned seg_len);
		push_request(seg_len[15:8], 1'b1);
		push_request(seg_len[7:0], 1'b0);
	endfunction

	function void push_table(logic [3:0] cls, logic [3:0] id, logic [7:0] cnt[16],
			int n_symbols);
		push_request({cls, id}, 1'b0);
		for (int i = 0; i < 16; i++)
			push_request(cnt[i], 1'b0);
		for (int i = 0; i < n_symbols; i++)
			push_request(8'($urandom_range(0, 255)), 1'b0);
	endfunction

	function void spread_counts(output logic [7:0] cnt[16], input int total);
		int lo;
		int idx;
		foreach (cnt[i])
			cnt[i] = 8'd0;
		// bias some tables toward long codes so many lengths get skipped
		lo = ($urandom_range(0, 3) == 0) ? 10 : 0;
		for (int s = 0; s < total; s++) begin
			idx = $urandom_range(15, lo);
			cnt[idx] = cnt[idx] + 8'd1;
		end
	endfunction

	function void build_segment(segment_kind_e kind);
		logic [7:0] cnt[16];
		logic [7:0] table_cnt[3][16];
		int totals[3];
		int tables;
		int seg_len;
		int extra;
		int pick;
		int start_at;
		int cut;
		start_at = requests.size();
		case (kind)
		SEG_GOOD: begin
			tables = $urandom_range(1, 3);
			seg_len = 2;
			for (int t = 0; t < tables; t++) begin
				pick = $urandom_range(0, 99);
				if (pick < 10)
					totals[t] = 0;
				else if (pick < 85)
					totals[t] = $urandom_range(1, 12);
				else
					totals[t] = $urandom_range(13, 40);
				spread_counts(cnt, totals[t]);
				table_cnt[t] = cnt;
				seg_len += 17 + totals[t];
			end
			extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
			push_length(seg_len + extra);
			for (int t = 0; t < tables; t++)
				push_table(4'($urandom_range(0, 1)), 4'($urandom_range(0, 3)), table_cnt[t],
					totals[t]);
			// a length longer than the tables leaves a header with too few bytes behind it
			if (extra != 0)
				push_request(8'($urandom_range(0, 255)), 1'b0);
			// drop the tail of some segments so the next start lands mid-table
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(start_at + 2, requests.size() - 1);
				while (requests.size() > cut)
					void'(requests.pop_back());
			end
		end
		SEG_EMPTY_TABLE: begin
			spread_counts(cnt, 0);
			push_length(19);
			push_table(4'($urandom_range(0, 1)), 4'($urandom_range(0, 3)), cnt, 0);
		end
		SEG_OVERFLOW: begin
			foreach (cnt[i])
				cnt[i] = 8'($urandom_range(16, 255));
			push_length($urandom_range(19, 65535));
			push_table(4'($urandom_range(0, 1)), 4'($urandom_range(0, 3)), cnt, 0);
		end
		SEG_TOO_FEW: begin
			pick = $urandom_range(1, 20);
			spread_counts(cnt, pick);
			push_length(19 + $urandom_range(0, pick - 1));
			push_table(4'($urandom_range(0, 1)), 4'($urandom_range(0, 3)), cnt, 0);
		end
		SEG_BAD_HEADER: begin
			push_length($urandom_range(19, 65535));
			if ($urandom_range(0, 1))
				push_request({4'($urandom_range(2, 15)), 4'($urandom_range(0, 15))}, 1'b0);
			else
				push_request({4'($urandom_range(0, 1)), 4'($urandom_range(4, 15))}, 1'b0);
			if ($urandom_range(0, 1)) begin
				push_request(8'($urandom_range(0, 255)), 1'b0);
				noise_count++;
			end
		end
		default: begin
			if ($urandom_range(0, 1))
				push_length($urandom_range(0, 2));
			else begin
				push_length($urandom_range(3, 18));
				push_request(8'($urandom_range(0, 255)), 1'b0);
			end
		end
		endcase
	endfunction

	task drive_requests();
		int i;
		bit showing;
		i = 0;
		showing = 0;
		while (i < requests.size()) begin
			case (i * 3 / requests.size())
			0: begin
				send_idle = 25;
				recv_idle = 64;
			end
			1: begin
				send_idle = 64;
				recv_idle = 25;
			end
			default: begin
				send_idle = 0;
				recv_idle = 0;
			end
			endcase
			if (!showing) begin
				if ($urandom_range(0, 99) >= send_idle) begin
					s_tvalid <= 1'b1;
					s_tdata <= requests[i].data;
					s_tuser <= requests[i].start;
					showing = 1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			@(posedge clk);
			if (showing && s_tready) begin
				sb.note_request(requests[i].data, requests[i].start);
				i++;
				showing = 0;
			end
		end
		s_tvalid <= 1'b0;
	endtask

	task drain_results();
		forever begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata, m_tlast);
		end
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'd0;
		s_tuser <= 1'b0;
		m_tready <= 1'b0;

		// stray bytes while idle
		push_request(8'hA5, 1'b0);
		push_request(8'h5A, 1'b0);
		// empty segments
		push_request(8'h00, 1'b1);
		push_request(8'h02, 1'b0);
		push_request(8'h00, 1'b1);
		push_request(8'h00, 1'b0);
		// too few bytes for a table
		push_request(8'h00, 1'b1);
		push_request(8'h05, 1'b0);
		push_request(8'h00, 1'b0);
		// bad class, bad id, and both bad with class reported
		push_request(8'h00, 1'b1);
		push_request(8'h40, 1'b0);
		push_request(8'h20, 1'b0);
		push_request(8'h00, 1'b1);
		push_request(8'h40, 1'b0);
		push_request(8'h14, 1'b0);
		push_request(8'hFF, 1'b1);
		push_request(8'hFF, 1'b0);
		push_request(8'hFF, 1'b0);
		// new segment start in the middle of the counts
		push_request(8'h00, 1'b1);
		push_request(8'h40, 1'b0);
		push_request(8'h01, 1'b0);
		push_request(8'h03, 1'b0);
		push_request(8'h00, 1'b1);
		push_request(8'h02, 1'b0);
		push_request(8'h77, 1'b0);
		directed_count = requests.size();

		for (int k = SEG_GOOD; k <= SEG_SHORT; k++)
			build_segment(segment_kind_e'(k));
		while (requests.size() - directed_count - noise_count < 230) begin
			case ($urandom_range(0, 24))
			0, 1: build_segment(SEG_EMPTY_TABLE);
			2, 3: build_segment(SEG_OVERFLOW);
			4, 5: build_segment(SEG_TOO_FEW);
			6, 7: build_segment(SEG_BAD_HEADER);
			8, 9: build_segment(SEG_SHORT);
			default: build_segment(SEG_GOOD);
			endcase
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			drain_results();
		join_none
		drive_requests();
		while (sb.expected_entries.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

@@ files.f @@
hw/rtl/dht_pkg.sv
hw/rtl/dht_cnt_ram.sv
hw/rtl/dht_out_reg.sv
hw/rtl/jpeg_dht_huffman_table_builder_top.sv
tb/sv/tb.sv
